### hdl/layer_blend_modes_defines.svh
// layer_blend_modes_defines.svh: assertion macros for the layer blend block.
// Expects clk and rst_n in the scope of use; the macros expand to nothing when SYNTH is set.
`ifndef LAYER_BLEND_MODES_DEFINES_SVH
`define LAYER_BLEND_MODES_DEFINES_SVH
`ifndef SYNTH
// Checked outside reset.
`define LBM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("layer_blend_modes: assertion failed");
// Checked on every edge, reset included.
`define LBM_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("layer_blend_modes: reset assertion failed");
`else
`define LBM_ASSERT(lbl, prop)
`define LBM_ASSERT_RST(lbl, prop)
`endif
`endif

### hdl/lbm_pkg.sv
// lbm_pkg.sv: widths, mode and register codes, and shared types of the layer blend block.
// No dependencies; imported by lbm_lane, lbm_merge and layer_blend_modes.
`timescale 1ns / 1ps

package lbm_pkg;

    // channel format: signed, CW bits, FW fraction bits
    localparam int CW        = 16;
    localparam int FW        = 12;
    localparam int OPW       = FW + 1;
    localparam int ONE       = 1 << FW;
    localparam int HALF      = 1 << (FW - 1);
    localparam int CH_MAX    = (1 << (CW - 1)) - 1;
    localparam int CH_MIN    = -(1 << (CW - 1));

    // datapath widths
    localparam int AW        = ((CW > OPW) ? CW : OPW) + 1;  // first multiplier operands
    localparam int P1W       = 2 * AW;                       // first product
    localparam int R1W       = P1W + 1 - FW;                 // rounded first product
    localparam int XW        = R1W + 1;                      // second multiplier, wide operand
    localparam int YW        = AW + 1;                       // second multiplier, narrow operand
    localparam int P2W       = XW + YW + 1;                  // second product plus addend
    localparam int RW        = P2W + 1 - FW;                 // lane result before saturation

    localparam int NUM_LANES  = 4;
    localparam int ALPHA_LANE = 3;

    // configuration port
    localparam int MODE_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = OPW;

    typedef logic signed [CW-1:0]  ch_t;
    typedef logic [OPW-1:0]        op_t;
    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DW-1:0]     cfg_data_t;
    typedef logic signed [R1W-1:0] r1_t;
    typedef logic signed [XW-1:0]  xop_t;
    typedef logic signed [YW-1:0]  yop_t;
    typedef logic signed [P2W-1:0] acc_t;

    localparam op_t OP_ONE = op_t'(ONE);

    localparam cfg_idx_t CFG_MODE    = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_OPACITY = cfg_idx_t'(1);

    localparam mode_t MODE_OVER   = mode_t'(0);
    localparam mode_t MODE_ADD    = mode_t'(1);
    localparam mode_t MODE_MUL    = mode_t'(2);
    localparam mode_t MODE_SUB    = mode_t'(3);
    localparam mode_t MODE_MIX    = mode_t'(4);
    localparam mode_t MODE_SCREEN = mode_t'(5);
    localparam mode_t MODE_DIFF   = mode_t'(6);
    localparam mode_t MODE_MAX    = mode_t'(7);
    localparam mode_t MODE_MIN    = mode_t'(8);

    // load enables of the three lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // what a lane hands to the merge stage
    typedef struct packed {
        acc_t acc;      // unrounded sum of products
        xop_t direct;   // result that needs no rounding
        logic use_acc;  // take rnd(acc) rather than direct
        logic clamp;    // clamp to [0, ONE] before saturation
    } lane_res_t;

endpackage

### hdl/layer_blend_modes.sv
// layer_blend_modes.sv: top level of the RGBA layer blend block, config registers and pipeline control.
// Depends on lbm_pkg, lbm_lane, lbm_merge and layer_blend_modes_defines.svh.
`timescale 1ns / 1ps
`include "layer_blend_modes_defines.svh"

// Blends a front RGBA pixel onto a back RGBA pixel under the blend_mode and
// opacity registers. Channels are signed Q3.12; every output saturates to
// that range. The block takes one pixel pair per clock while in_ready is
// high and returns one pixel per pair, in order. The accepting edge loads
// the first of three lane stages (first multiply, round and mode select,
// second multiply-add). The output register, where the lanes are merged,
// rounded, clamped and saturated, loads from the third lane stage. The two
// registered multipliers in each of the four channel lanes set the depth
// of the lanes. Each stage moves on as soon as the one after it has room,
// so a waiting result does not keep the input from taking new transactions
// until the pipeline holds four of them.
// Configuration writes are always taken (cfg_ready is tied high) and
// must only be issued while no transaction is in flight; opacity above
// 4096 is stored as 4096, and mode codes 9 to 15 pass the back pixel through.

module layer_blend_modes (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  lbm_pkg::cfg_idx_t   cfg_index,
    input  lbm_pkg::cfg_data_t  cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  lbm_pkg::ch_t        back_red,
    input  lbm_pkg::ch_t        back_green,
    input  lbm_pkg::ch_t        back_blue,
    input  lbm_pkg::ch_t        back_alpha,
    input  lbm_pkg::ch_t        front_red,
    input  lbm_pkg::ch_t        front_green,
    input  lbm_pkg::ch_t        front_blue,
    input  lbm_pkg::ch_t        front_alpha,

    output logic                out_valid,
    input  logic                out_ready,
    output lbm_pkg::ch_t        out_red,
    output lbm_pkg::ch_t        out_green,
    output lbm_pkg::ch_t        out_blue,
    output lbm_pkg::ch_t        out_alpha
);
    import lbm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    mode_t mode_reg;
    mode_t mode_next;
    op_t   opacity_reg;
    op_t   opacity_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        opacity_next = opacity_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                end
                CFG_OPACITY:
                begin
                    // anything above fully opaque is stored as fully opaque
                    opacity_next = (cfg_data > OP_ONE) ? OP_ONE : cfg_data;
                end
                default:
                begin
                    // unmapped index: write is dropped
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OVER;
            opacity_reg <= OP_ONE;
        end
        else
        begin
            mode_reg    <= mode_next;
            opacity_reg <= opacity_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when the one after it is empty or
    // is itself moving on this cycle.
    // ------------------------------------------------------------------
    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      v1_next;
    logic      v2_next;
    logic      v3_next;
    logic      rdy1;
    logic      rdy2;
    logic      rdy3;
    logic      rdy_m;
    stage_en_t en;

    assign rdy_m    = !out_valid || out_ready;
    assign rdy3     = !v3_reg || rdy_m;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign en.s1 = rdy1 && in_valid;
    assign en.s2 = rdy2 && v1_reg;
    assign en.s3 = rdy3 && v2_reg;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes: red, green, blue, alpha. The over mode needs the
    // scaled front alpha in every color lane, so the alpha lane's rounded
    // first product is fanned out to all of them.
    // ------------------------------------------------------------------
    ch_t       back_ch    [NUM_LANES];
    ch_t       front_ch   [NUM_LANES];
    r1_t       lane_scaled[NUM_LANES];
    lane_res_t lane_res   [NUM_LANES];
    ch_t       merged     [NUM_LANES];

    assign back_ch[0]  = back_red;
    assign back_ch[1]  = back_green;
    assign back_ch[2]  = back_blue;
    assign back_ch[3]  = back_alpha;
    assign front_ch[0] = front_red;
    assign front_ch[1] = front_green;
    assign front_ch[2] = front_blue;
    assign front_ch[3] = front_alpha;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        lbm_lane u_lane (
            .clk          (clk),
            .is_alpha     (g == ALPHA_LANE),
            .en           (en),
            .mode         (mode_reg),
            .opacity      (opacity_reg),
            .back         (back_ch[g]),
            .front        (front_ch[g]),
            .alpha_scaled (lane_scaled[ALPHA_LANE]),
            .scaled       (lane_scaled[g]),
            .res          (lane_res[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge stage and output register
    // ------------------------------------------------------------------
    lbm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rdy_m),
        .in_valid  (v3_reg),
        .res       (lane_res),
        .out_valid (out_valid),
        .out_ch    (merged)
    );

    assign out_red   = merged[0];
    assign out_green = merged[1];
    assign out_blue  = merged[2];
    assign out_alpha = merged[3];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LBM_ASSERT(a_accept_fills_s1, in_valid && in_ready |=> v1_reg)
    `LBM_ASSERT(a_s3_holds_on_stall, v3_reg && !rdy3 |=> v3_reg)
    `LBM_ASSERT(a_opacity_in_range, cfg_valid && cfg_ready && (cfg_index == CFG_OPACITY) |=> (opacity_reg <= OP_ONE))
    `LBM_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && !v1_reg && !v2_reg && !v3_reg)

endmodule

### hdl/lbm_lane.sv
// lbm_lane.sv: one channel of the blend datapath, three registered stages.
// Depends on lbm_pkg; instantiated four times by layer_blend_modes.
`timescale 1ns / 1ps

module lbm_lane (
    input  logic                clk,
    input  logic                is_alpha,
    input  lbm_pkg::stage_en_t  en,
    input  lbm_pkg::mode_t      mode,
    input  lbm_pkg::op_t        opacity,
    input  lbm_pkg::ch_t        back,
    input  lbm_pkg::ch_t        front,
    input  lbm_pkg::r1_t        alpha_scaled,
    output lbm_pkg::r1_t        scaled,
    output lbm_pkg::lane_res_t  res
);
    import lbm_pkg::*;

    localparam logic signed [AW-1:0] ONE_A = AW'(ONE);

    function automatic xop_t clamp01(xop_t v);
        xop_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > XW'(ONE))
        begin
            r = XW'(ONE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // stage 1: first multiply, f*op or (ONE-f)*(ONE-b) for screen in the color lanes
    logic signed [AW-1:0]  back_a;
    logic signed [AW-1:0]  front_a;
    logic signed [AW-1:0]  mul_a;
    logic signed [AW-1:0]  mul_b;
    logic signed [P1W-1:0] prod1;
    logic signed [P1W-1:0] prod1_reg;
    ch_t                   back1_reg;
    ch_t                   front1_reg;

    always_comb
    begin
        back_a  = AW'(back);
        front_a = AW'(front);
        if (mode == MODE_SCREEN && !is_alpha)
        begin
            mul_a = ONE_A - front_a;
            mul_b = ONE_A - back_a;
        end
        else
        begin
            mul_a = front_a;
            mul_b = $signed(AW'({1'b0, opacity}));
        end
        prod1 = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod1_reg  <= prod1;
            back1_reg  <= back;
            front1_reg <= front;
        end
    end

    // stage 2: round, mode selection, operands for the second multiply
    logic [P1W:0] p1_round;
    r1_t          r1;
    xop_t         bx;
    xop_t         fx;
    xop_t         r1x;
    xop_t         d_bf;
    xop_t         scr;
    xop_t         s;
    acc_t         add_next;
    xop_t         x_next;
    yop_t         y_next;
    xop_t         dir_next;
    logic         use_next;
    logic         clamp_next;
    acc_t         add2_reg;
    xop_t         x2_reg;
    yop_t         y2_reg;
    xop_t         dir2_reg;
    logic         use2_reg;
    logic         clamp2_reg;

    assign p1_round = {prod1_reg[P1W-1], prod1_reg} + (P1W+1)'(HALF);
    assign r1       = p1_round[P1W:FW];
    assign scaled   = r1;

    always_comb
    begin
        bx         = XW'(back1_reg);
        fx         = XW'(front1_reg);
        r1x        = XW'(r1);
        d_bf       = bx - fx;
        scr        = XW'(ONE) - r1x;
        s          = bx;
        add_next   = P2W'(bx) <<< FW;
        x_next     = '0;
        y_next     = $signed(YW'({1'b0, opacity}));
        dir_next   = bx;
        use_next   = 1'b0;
        clamp_next = 1'b0;
        unique case (mode)
            MODE_OVER:
            begin
                // color: f*op + b*(ONE-a), alpha: a + ba
                add_next   = P2W'(prod1_reg);
                x_next     = bx;
                y_next     = YW'(R1W'(ONE) - alpha_scaled);
                dir_next   = r1x + bx;
                use_next   = !is_alpha;
                clamp_next = is_alpha;
            end
            MODE_ADD:
            begin
                dir_next   = r1x + bx;
                clamp_next = is_alpha;
            end
            MODE_MUL:
            begin
                add_next = '0;
                x_next   = r1x + XW'(ONE) - $signed(XW'({1'b0, opacity}));
                y_next   = YW'(back1_reg);
                use_next = 1'b1;
            end
            MODE_SUB:
            begin
                dir_next   = bx - r1x;
                clamp_next = is_alpha;
            end
            MODE_MIX:
            begin
                x_next     = fx - bx;
                use_next   = 1'b1;
                clamp_next = is_alpha;
            end
            MODE_SCREEN:
            begin
                if (is_alpha)
                begin
                    s = clamp01(fx + bx);
                end
                else
                begin
                    s = (scr < bx) ? bx : scr;
                end
                x_next   = s - bx;
                use_next = 1'b1;
            end
            MODE_DIFF:
            begin
                if (is_alpha)
                begin
                    s = clamp01(d_bf);
                end
                else
                begin
                    s = d_bf[XW-1] ? -d_bf : d_bf;
                end
                x_next   = s - bx;
                use_next = 1'b1;
            end
            MODE_MAX:
            begin
                s        = (fx > bx) ? fx : bx;
                x_next   = s - bx;
                use_next = 1'b1;
            end
            MODE_MIN:
            begin
                s        = (fx < bx) ? fx : bx;
                x_next   = s - bx;
                use_next = 1'b1;
            end
            default:
            begin
                dir_next = bx;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            add2_reg   <= add_next;
            x2_reg     <= x_next;
            y2_reg     <= y_next;
            dir2_reg   <= dir_next;
            use2_reg   <= use_next;
            clamp2_reg <= clamp_next;
        end
    end

    // stage 3: second multiply-add; lerp is b*ONE + (s-b)*op
    acc_t      acc_next;
    lane_res_t res_reg;

    assign acc_next = add2_reg + x2_reg * y2_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            res_reg.acc     <= acc_next;
            res_reg.direct  <= dir2_reg;
            res_reg.use_acc <= use2_reg;
            res_reg.clamp   <= clamp2_reg;
        end
    end

    assign res = res_reg;

endmodule

### hdl/lbm_merge.sv
// lbm_merge.sv: final rounding, alpha clamp and saturation of all lanes into the output register.
// Depends on lbm_pkg; instantiated by layer_blend_modes.
`timescale 1ns / 1ps

module lbm_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               in_valid,
    input  lbm_pkg::lane_res_t res [lbm_pkg::NUM_LANES],
    output logic               out_valid,
    output lbm_pkg::ch_t       out_ch [lbm_pkg::NUM_LANES]
);
    import lbm_pkg::*;

    function automatic ch_t finish_lane(lane_res_t r);
        logic [P2W:0]         rsum;
        logic signed [RW-1:0] v;
        rsum = {r.acc[P2W-1], r.acc} + (P2W+1)'(HALF);
        v    = r.use_acc ? $signed(rsum[P2W:FW]) : RW'(r.direct);
        if (r.clamp)
        begin
            if (v < 0)
            begin
                v = '0;
            end
            else if (v > RW'(ONE))
            begin
                v = RW'(ONE);
            end
        end
        if (v > RW'(CH_MAX))
        begin
            v = RW'(CH_MAX);
        end
        else if (v < RW'(CH_MIN))
        begin
            v = RW'(CH_MIN);
        end
        return CW'(v);
    endfunction

    logic out_valid_reg;
    logic out_valid_next;
    ch_t  ch_reg  [NUM_LANES];
    ch_t  ch_next [NUM_LANES];

    always_comb
    begin
        out_valid_next = load ? in_valid : out_valid_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            ch_next[i] = finish_lane(res[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            ch_reg <= ch_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ch    = ch_reg;

endmodule
